FILE: hdl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

	// Fixed field widths
	localparam int unsigned CMD_W   = 1;
	localparam int unsigned CHAN_W  = 3;
	localparam int unsigned ECHO_W  = 6;
	localparam int unsigned TRIG_W  = 6;
	localparam int unsigned DIST_W  = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned TWID_W  = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Stream widths, padded to whole bytes
	localparam int unsigned S_DATA_W = 16;
	localparam int unsigned M_DATA_W = 32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_DISTANCE = 2'd2;

	// Register reset values
	localparam logic [TWID_W-1:0]  TRIGGER_WIDTH_RST    = 8'd10;
	localparam logic [COUNT_W-1:0] TIMEOUT_TICKS_RST    = 16'd20000;
	localparam logic [DIST_W-1:0]  TIMEOUT_DISTANCE_RST = 16'd400;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
	localparam logic [CMD_W-1:0] CMD_START = 1'b1;

	// Phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TRIG = 2'd1;
	localparam logic [1:0] PH_RISE = 2'd2;
	localparam logic [1:0] PH_FALL = 2'd3;

	// floor(2t/115) == (t * RECIP) >> RECIP_SHIFT for t < 2^16
	localparam int unsigned RECIP_W     = 18;
	localparam logic [RECIP_W-1:0] RECIP = 18'd145889;
	localparam int unsigned RECIP_SHIFT = 23;
	localparam int unsigned PROD_W      = COUNT_W + RECIP_W;
	localparam int unsigned QUOT_W      = 11;

	typedef struct packed {
		logic [ECHO_W-1:0] echo_levels;
		logic [CHAN_W-1:0] channel;
		logic [CMD_W-1:0]  command;
	} item_t;

	typedef struct packed {
		logic              busy_res;
		logic              timed_out;
		logic              result_valid;
		logic [DIST_W-1:0] distance_cm;
		logic [TRIG_W-1:0] trigger_pins;
	} result_t;

	localparam int unsigned RES_W = $bits(result_t);

endpackage

FILE: hdl/ultrasonic_echo_ranger.sv
// Ultrasonic echo ranger: tick/start stream in, one status/result beat out per beat.
// Usage
//   Slave stream carries one beat per microsecond tick or start command:
//   tuser = command (0 tick, 1 start), tdata = channel, echo_levels.
//   Master stream returns exactly one beat per input beat with the trigger
//   pin drive, distance, result/timeout flags and busy status after the update.
//   A start picks a sensor and holds its trigger pin for trigger_width ticks;
//   the echo pulse width t (ticks) is reported as floor(2t/115) cm, or
//   timeout_distance with timed_out set once the count passes timeout_ticks.
//   Starts while busy, and starts to a channel at or above NUM_SENSORS, are ignored.
// Timing
//   Input register, then update logic (one 16x18 multiply for the distance)
//   into the output register; a stall on the output holds the beat in the
//   input register. One beat per cycle while m_axis_tready stays high.
// Reset: arst_n clears the measurement state to idle and loads the register
//   defaults (trigger_width 10, timeout_ticks 20000, timeout_distance 400).
// Stall: while m_axis_tready is low the output beat holds; one more input beat
//   is taken into the input register, then s_axis_tready drops.
// Config: cfg_we/cfg_index/cfg_wdata write a register at the clock edge; write
//   only while no beat is in flight. Unknown indexes are ignored.
module ultrasonic_echo_ranger #(
	parameter int unsigned NUM_SENSORS = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [uer_pkg::S_DATA_W-1:0]    s_axis_tdata,  // [2:0] channel, [8:3] echo_levels, rest 0
	input  logic [uer_pkg::CMD_W-1:0]       s_axis_tuser,  // [0] command
	// output stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [uer_pkg::M_DATA_W-1:0]    m_axis_tdata,  // [5:0] trigger_pins, [21:6] distance_cm,
	                                                       // [22] result_valid, [23] timed_out,
	                                                       // [24] busy_res, rest 0
	// register writes
	input  logic                            cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam logic [3:0] NUM_SENS_4 = 4'(NUM_SENSORS);

	// configuration registers
	logic [uer_pkg::TWID_W-1:0]  trigger_width_q;
	logic [uer_pkg::COUNT_W-1:0] timeout_ticks_q;
	logic [uer_pkg::DIST_W-1:0]  timeout_distance_q;

	// measurement state
	logic [1:0]                  phase_q;
	logic [uer_pkg::COUNT_W-1:0] tick_count_q;
	logic [uer_pkg::CHAN_W-1:0]  active_sensor_q;
	logic                        last_echo_q;

	// pipeline
	logic           item_valid_s1;
	uer_pkg::item_t item_s1;
	logic           res_valid_s2;
	uer_pkg::result_t res_s2;
	logic           advance;

	// next-state logic
	logic [1:0]                  phase_d;
	logic [uer_pkg::COUNT_W-1:0] tick_count_d;
	logic [uer_pkg::CHAN_W-1:0]  active_sensor_d;
	logic                        last_echo_d;
	uer_pkg::result_t            res_d;
	logic [7:0]                  echo_ext;
	logic                        lvl;
	logic [uer_pkg::COUNT_W:0]   next_cnt;
	logic [uer_pkg::PROD_W-1:0]  prod;
	logic [7:0]                  trig_onehot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_width_q    <= uer_pkg::TRIGGER_WIDTH_RST;
			timeout_ticks_q    <= uer_pkg::TIMEOUT_TICKS_RST;
			timeout_distance_q <= uer_pkg::TIMEOUT_DISTANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				uer_pkg::REG_TRIGGER_WIDTH: begin
					trigger_width_q <= cfg_wdata[uer_pkg::TWID_W-1:0];
				end
				uer_pkg::REG_TIMEOUT_TICKS: begin
					timeout_ticks_q <= cfg_wdata;
				end
				uer_pkg::REG_TIMEOUT_DISTANCE: begin
					timeout_distance_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// s1 drains into the output register when that register is free or being taken
	assign advance       = item_valid_s1 && (!res_valid_s2 || m_axis_tready);
	assign s_axis_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			item_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.command     <= s_axis_tuser;
			item_s1.channel     <= s_axis_tdata[uer_pkg::CHAN_W-1:0];
			item_s1.echo_levels <= s_axis_tdata[uer_pkg::CHAN_W +: uer_pkg::ECHO_W];
		end
	end

	// echo bits above the sensor pins read as zero
	assign echo_ext = {2'b00, item_s1.echo_levels};
	assign lvl      = echo_ext[active_sensor_q];
	assign next_cnt = {1'b0, tick_count_q} + 17'd1;
	// pulse width to centimeters by reciprocal multiply
	assign prod     = tick_count_q * uer_pkg::RECIP;

	always_comb begin
		phase_d         = phase_q;
		tick_count_d    = tick_count_q;
		active_sensor_d = active_sensor_q;
		last_echo_d     = last_echo_q;
		res_d           = '0;

		if (item_s1.command == uer_pkg::CMD_START) begin
			if (phase_q == uer_pkg::PH_IDLE && {1'b0, item_s1.channel} < NUM_SENS_4) begin
				active_sensor_d = item_s1.channel;
				phase_d         = uer_pkg::PH_TRIG;
				tick_count_d    = '0;
				last_echo_d     = echo_ext[item_s1.channel];
			end
		end else if (phase_q != uer_pkg::PH_IDLE) begin
			if (phase_q == uer_pkg::PH_TRIG) begin
				// a width of zero ends after one tick, same as one
				if (next_cnt >= {9'd0, trigger_width_q}) begin
					tick_count_d = '0;
					phase_d      = uer_pkg::PH_RISE;
				end else begin
					tick_count_d = next_cnt[uer_pkg::COUNT_W-1:0];
				end
			end else if (phase_q == uer_pkg::PH_RISE && lvl && !last_echo_q) begin
				tick_count_d = '0;
				phase_d      = uer_pkg::PH_FALL;
			end else if (phase_q == uer_pkg::PH_FALL && !lvl && last_echo_q) begin
				res_d.distance_cm  = {{(uer_pkg::DIST_W - uer_pkg::QUOT_W){1'b0}},
					prod[uer_pkg::RECIP_SHIFT +: uer_pkg::QUOT_W]};
				res_d.result_valid = 1'b1;
				tick_count_d       = '0;
				phase_d            = uer_pkg::PH_IDLE;
			end else if (next_cnt > {1'b0, timeout_ticks_q}) begin
				res_d.distance_cm  = timeout_distance_q;
				res_d.result_valid = 1'b1;
				res_d.timed_out    = 1'b1;
				tick_count_d       = '0;
				phase_d            = uer_pkg::PH_IDLE;
			end else begin
				tick_count_d = next_cnt[uer_pkg::COUNT_W-1:0];
			end
			last_echo_d = lvl;
		end

		// trigger pins beyond the six outputs are dropped
		trig_onehot = 8'd1 << active_sensor_d;
		res_d.trigger_pins = (phase_d == uer_pkg::PH_TRIG) ?
			trig_onehot[uer_pkg::TRIG_W-1:0] : '0;
		res_d.busy_res = (phase_d != uer_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= uer_pkg::PH_IDLE;
			tick_count_q    <= '0;
			active_sensor_q <= '0;
			last_echo_q     <= 1'b0;
		end else if (advance) begin
			phase_q         <= phase_d;
			tick_count_q    <= tick_count_d;
			active_sensor_q <= active_sensor_d;
			last_echo_q     <= last_echo_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = res_valid_s2;
	assign m_axis_tdata  = {{(uer_pkg::M_DATA_W - uer_pkg::RES_W){1'b0}}, res_s2};

	// a finished measurement always leaves the block idle
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.result_valid |-> !res_s2.busy_res)
		else $error("result reported while still busy");

	// timeout flag only comes with a result
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.timed_out |-> res_s2.result_valid)
		else $error("timeout without result");

	// idle always holds a cleared counter
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == uer_pkg::PH_IDLE |-> tick_count_q == '0)
		else $error("counter not cleared in idle");

	// at most one trigger pin, and only during a measurement
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> $onehot0(res_s2.trigger_pins) &&
			(res_s2.trigger_pins == '0 || res_s2.busy_res))
		else $error("bad trigger drive");

endmodule
